>>> hdl/pwsfd_pkg.sv
// shared types and constants for the pulse width sensor frame decoder
package pwsfd_pkg;

   localparam int DURATION_WIDTH = 15;
   localparam int SHIFT_WIDTH = 40;
   localparam int COUNT_WIDTH = 7;
   localparam int VALUE_WIDTH = 16;

   localparam logic [DURATION_WIDTH-1:0] THRESHOLD_RESET = 15'd45;
   localparam logic [COUNT_WIDTH-1:0] MIN_FRAME_SYMBOLS = 7'd41;
   localparam logic [COUNT_WIDTH-1:0] COUNT_SATURATE = 7'd64;
   localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = 16'h8000;
   localparam logic [VALUE_WIDTH-1:0] MAG_MASK = 16'h7FFF;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_FRAME_ERR   = 2'd1,
      STATUS_NO_RESPONSE = 2'd2,
      STATUS_NOT_PRESENT = 2'd3
   } read_status_type;

   typedef struct packed {
      logic [DURATION_WIDTH-1:0] high_duration_us;
      logic                      frame_end;
      logic                      capture_failed;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]        humidity_x10;
      logic signed [VALUE_WIDTH-1:0] temperature_x10;
      read_status_type               read_status;
   } rsp_item_type;

   // handshake between the frame core and the output register
   typedef struct packed {
      logic load;
      logic space;
   } rsp_ctrl_type;

endpackage

>>> hdl/pwsfd_req_stage.sv
// input register for symbol requests
module pwsfd_req_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pwsfd_pkg::req_item_type req_item,
   input  logic                  item_take,
   output logic                  item_valid,
   output pwsfd_pkg::req_item_type item
);

   logic                    valid_ff, valid_in;
   pwsfd_pkg::req_item_type item_ff;

   // a new request may enter when the held one leaves in the same cycle
   assign req_tready = !valid_ff || item_take;
   assign valid_in = (req_tvalid && req_tready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

>>> hdl/pwsfd_frame_core.sv
// bit decode, frame checks and held sensor values
module pwsfd_frame_core (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_wr_en,
   input  logic [pwsfd_pkg::DURATION_WIDTH-1:0]       csr_wr_data,
   input  logic                                       item_valid,
   input  pwsfd_pkg::req_item_type                    item,
   output logic                                       item_take,
   output pwsfd_pkg::rsp_ctrl_type                    rsp_ctrl_load,
   input  logic                                       rsp_space,
   output pwsfd_pkg::rsp_item_type                    rsp_item
);

   logic [pwsfd_pkg::DURATION_WIDTH-1:0] threshold_ff;
   logic [pwsfd_pkg::SHIFT_WIDTH-1:0]    shift_ff, shift_in;
   logic [pwsfd_pkg::COUNT_WIDTH-1:0]    count_ff, count_in, count_step;
   logic [pwsfd_pkg::VALUE_WIDTH-1:0]    humidity_ff, humidity_in;
   logic [pwsfd_pkg::VALUE_WIDTH-1:0]    temperature_ff, temperature_in;
   pwsfd_pkg::read_status_type           status_ff, status_in;

   logic [pwsfd_pkg::SHIFT_WIDTH-1:0] shifted;
   logic [7:0]                        b0, b1, b2, b3, b4, sum;
   logic [pwsfd_pkg::VALUE_WIDTH-1:0] raw_t, mag, conv_t;
   logic                              emits, frame_good;

   assign shifted = {shift_ff[pwsfd_pkg::SHIFT_WIDTH-2:0],
                     item.high_duration_us > threshold_ff};
   assign count_step = (count_ff < pwsfd_pkg::COUNT_SATURATE) ?
                       count_ff + 7'd1 : count_ff;

   assign b0 = shifted[39:32];
   assign b1 = shifted[31:24];
   assign b2 = shifted[23:16];
   assign b3 = shifted[15:8];
   assign b4 = shifted[7:0];
   assign sum = b0 + b1 + b2 + b3;
   assign frame_good = (count_step >= pwsfd_pkg::MIN_FRAME_SYMBOLS) && (sum == b4);

   // sign-magnitude to two's complement, negative zero becomes zero
   assign raw_t = {b2, b3};
   assign mag = raw_t & pwsfd_pkg::MAG_MASK;
   assign conv_t = ((raw_t & pwsfd_pkg::SIGN_BIT) != '0) ? (16'd0 - mag) : raw_t;

   assign emits = item.capture_failed || item.frame_end;
   assign item_take = item_valid && (!emits || rsp_space);
   assign rsp_ctrl_load.load = item_take && emits;
   assign rsp_ctrl_load.space = rsp_space;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      humidity_in = humidity_ff;
      temperature_in = temperature_ff;
      status_in = status_ff;
      if (item_take) begin
         priority if (item.capture_failed) begin
            status_in = pwsfd_pkg::STATUS_NO_RESPONSE;
            shift_in = '0;
            count_in = '0;
         end else if (item.frame_end) begin
            shift_in = '0;
            count_in = '0;
            if (frame_good) begin
               humidity_in = {b0, b1};
               temperature_in = conv_t;
               status_in = pwsfd_pkg::STATUS_OK;
            end else begin
               status_in = pwsfd_pkg::STATUS_FRAME_ERR;
            end
         end else begin
            shift_in = shifted;
            count_in = count_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= pwsfd_pkg::THRESHOLD_RESET;
         shift_ff <= '0;
         count_ff <= '0;
         humidity_ff <= '0;
         temperature_ff <= '0;
         status_ff <= pwsfd_pkg::STATUS_NOT_PRESENT;
      end else begin
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         shift_ff <= shift_in;
         count_ff <= count_in;
         humidity_ff <= humidity_in;
         temperature_ff <= temperature_in;
         status_ff <= status_in;
      end
   end

   assign rsp_item.humidity_x10 = humidity_in;
   assign rsp_item.temperature_x10 = temperature_in;
   assign rsp_item.read_status = status_in;

endmodule

>>> hdl/pwsfd_rsp_stage.sv
// output register for result requests
module pwsfd_rsp_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  pwsfd_pkg::rsp_ctrl_type rsp_ctrl,
   input  pwsfd_pkg::rsp_item_type rsp_item,
   output logic                    rsp_space,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output pwsfd_pkg::rsp_item_type rsp_out
);

   logic                    valid_ff, valid_in;
   pwsfd_pkg::rsp_item_type item_ff;

   assign rsp_space = !valid_ff || rsp_tready;
   assign valid_in = rsp_ctrl.load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctrl.load && rsp_ctrl.space) begin
         item_ff <= rsp_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_out = item_ff;

endmodule

>>> hdl/pulse_width_sensor_frame_decoder_unit.sv
// top level of the pulse width sensor frame decoder
//
//   port group   direction   contents
//   req_*        in          one captured symbol per request
//   rsp_*        out         held humidity and temperature with status
//   csr_*        in          bit threshold write
//
// a request passes the input register, then decode and state update into the
// output register. one request per cycle is taken while the result side keeps
// up. a symbol that ends a frame or reports a failed capture waits in the input
// register while the output register holds an untaken result. reset is
// synchronous and clears the valid flags of both registers.
module pulse_width_sensor_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] high_duration_us, [15] zero
   input  logic        req_tlast,   // frame_end
   input  logic        req_tuser,   // capture_failed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] humidity_x10, [31:16] temperature_x10
   output logic [1:0]  rsp_tuser,   // read_status
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data  // bit_threshold_us
);

   pwsfd_pkg::req_item_type req_item, item;
   pwsfd_pkg::rsp_item_type core_item, rsp_out;
   pwsfd_pkg::rsp_ctrl_type rsp_ctrl;
   logic                    item_valid, item_take, rsp_space;

   assign req_item.high_duration_us = req_tdata[14:0];
   assign req_item.frame_end = req_tlast;
   assign req_item.capture_failed = req_tuser;

   pwsfd_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   pwsfd_frame_core u_frame_core (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .rsp_ctrl_load (rsp_ctrl),
      .rsp_space     (rsp_space),
      .rsp_item      (core_item)
   );

   pwsfd_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .rsp_ctrl   (rsp_ctrl),
      .rsp_item   (core_item),
      .rsp_space  (rsp_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_out    (rsp_out)
   );

   assign rsp_tdata = {rsp_out.temperature_x10, rsp_out.humidity_x10};
   assign rsp_tuser = rsp_out.read_status;

endmodule
